/* rtl/ftrm_pkg.sv */
// shared types and constants for the fan tachometer rpm meter
`default_nettype none

package ftrm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned MulBW = 16;

  localparam logic [MulBW-1:0] MsPerMin = 16'd60000;
  localparam logic [MulBW-1:0] UsPerMs  = 16'd1000;
  localparam logic [DataW-1:0] UsPerMin = 32'd60000000;

  typedef enum logic [1:0] {
    CMD_EDGE    = 2'd0,
    CMD_WINDOW  = 2'd1,
    CMD_INSTANT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PPR     = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef enum logic {
    KIND_WINDOW  = 1'b0,
    KIND_INSTANT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN_DEN,
    ST_WIN_NUM,
    ST_INS_TMO,
    ST_INS_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/ftrm_mul.sv */
// shared registered multiplier, low 32 bits of a 32 by 16 product
`default_nettype none

module ftrm_mul
  import ftrm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [DataW-1:0] a_i,
  input  wire logic [MulBW-1:0] b_i,
  output logic      [DataW-1:0] p_o
);

  logic [DataW+MulBW-1:0] prod;
  logic [DataW-1:0]       p_q;

  assign prod = a_i * b_i;

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    p_q <= prod[DataW-1:0];
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/ftrm_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module ftrm_div
  import ftrm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DataW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // trial subtract, keep it when it does not go negative
      if (!diff[DataW+1]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* rtl/fan_tach_rpm_meter.sv */
// top level of the fan tachometer rpm meter: sequencer, state and stream ports
`default_nettype none

// Fan speed meter driven by a command stream. Each input beat carries a
// command in tuser: a tach falling edge, a windowed rpm query or an instant
// rpm query (code 3 is dropped). An edge counts a pulse, stamps now_us and
// folds the edge period into a filter ((3*old+new)/4, the first period
// seeds it); it gives no output beat. A windowed query gives
// count*60000/(elapsed_ms*pulses_per_rev) once window_ms has gone by, then
// clears the count and restarts the window; an early query answers 0, as
// does a zero denominator. An instant query gives
// 60000000/(period*pulses_per_rev), or 0 with no edge, no period, a zero
// pulses_per_rev, a zero denominator or an edge older than timeout_ms. A
// full query makes two passes through one shared 32x16 multiplier, then a
// 32-step radix-2 divider, one quotient bit per cycle. The input is not
// ready while a query is being worked on; a finished answer sits in an
// output register so the next beat can be taken while it waits. All
// arithmetic wraps at 32 bits. Configuration writes are registered and
// always ready; write them only while idle.

module fan_tach_rpm_meter
  import ftrm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // command stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,  // [31:0] now_us, [63:32] now_ms
  input  wire logic [1:0]       s_axis_tuser,  // [1:0] cmd
  // answer stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [31:0]      m_axis_tdata,  // [31:0] rpm
  output logic                  m_axis_tuser,  // [0] query_kind
  // register writes
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [DataW-1:0] cfg_data_i
);

  // configuration
  logic [7:0]       ppr_q;
  logic [DataW-1:0] window_q, timeout_q;

  // measurement state
  logic [DataW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] ws_q, ws_d;
  logic [DataW-1:0] last_q, last_d;
  logic [DataW-1:0] pf_q, pf_d;
  logic             seen_q, seen_d;

  // sequencer and working registers
  state_e           state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [DataW-1:0] us_q, us_d;
  logic [DataW-1:0] elap_q, elap_d;
  logic [DataW-1:0] puls_q, puls_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW-1:0] res_q, res_d;

  // output register
  logic             ov_q, ov_d;
  logic [DataW-1:0] orpm_q, orpm_d;
  logic             okind_q, okind_d;

  // shared units
  logic [DataW-1:0] mul_a, mul_p;
  logic [MulBW-1:0] mul_b;
  logic             div_start, div_done;
  logic [DataW-1:0] div_num, div_den, div_quot;

  logic             in_acc;
  cmd_e             cmd;
  logic [DataW-1:0] now_us, now_ms;
  logic [DataW-1:0] delta, filt, elapsed, age;
  logic             out_free;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign now_us = s_axis_tdata[31:0];
  assign now_ms = s_axis_tdata[63:32];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // edge period filter, wraps like the 32-bit sum it is
  assign delta   = now_us - last_q;
  assign filt    = (pf_q + {pf_q[DataW-2:0], 1'b0} + delta) >> 2;
  assign elapsed = now_ms - ws_q;
  assign age     = us_q - last_q;

  ftrm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ftrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // instant: 60000000 over the product just made; windowed: product just made over stored den
  assign div_num = (kind_q == KIND_INSTANT) ? UsPerMin : mul_p;
  assign div_den = (kind_q == KIND_INSTANT) ? mul_p : den_q;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    us_d      = us_q;
    elap_d    = elap_q;
    puls_d    = puls_q;
    den_d     = den_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    ws_d      = ws_q;
    last_d    = last_q;
    pf_d      = pf_q;
    seen_d    = seen_q;
    ov_d      = ov_q;
    orpm_d    = orpm_q;
    okind_d   = okind_q;
    mul_a     = pf_q;
    mul_b     = MulBW'(ppr_q);
    div_start = 1'b0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_EDGE: begin
              cnt_d = cnt_q + 1'b1;
              if (seen_q) begin
                pf_d = (pf_q == '0) ? delta : filt;
              end
              last_d = now_us;
              seen_d = 1'b1;
            end
            CMD_WINDOW: begin
              kind_d = KIND_WINDOW;
              if (elapsed < window_q) begin
                res_d   = '0;
                state_d = ST_OUT;
              end else begin
                elap_d  = elapsed;
                puls_d  = cnt_q;
                cnt_d   = '0;
                ws_d    = now_ms;
                state_d = ST_WIN_DEN;
              end
            end
            CMD_INSTANT: begin
              kind_d = KIND_INSTANT;
              us_d   = now_us;
              if (!seen_q || pf_q == '0 || ppr_q == '0) begin
                res_d   = '0;
                state_d = ST_OUT;
              end else begin
                state_d = ST_INS_TMO;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WIN_DEN: begin
        mul_a   = elap_q;
        mul_b   = MulBW'(ppr_q);
        state_d = ST_WIN_NUM;
      end
      ST_WIN_NUM: begin
        den_d   = mul_p;
        mul_a   = puls_q;
        mul_b   = MsPerMin;
        state_d = ST_DIV_GO;
      end
      ST_INS_TMO: begin
        mul_a   = timeout_q;
        mul_b   = UsPerMs;
        state_d = ST_INS_DEN;
      end
      ST_INS_DEN: begin
        // an age equal to the timeout still counts
        mul_a = pf_q;
        mul_b = MulBW'(ppr_q);
        if (age > mul_p) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        if (div_den == '0) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_d   = div_quot;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          orpm_d  = res_q;
          okind_d = kind_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ws_q      <= '0;
      last_q    <= '0;
      pf_q      <= '0;
      seen_q    <= 1'b0;
      ov_q      <= 1'b0;
      ppr_q     <= 8'd2;
      window_q  <= 32'd1000;
      timeout_q <= 32'd500;
    end else begin
      cnt_q  <= cnt_d;
      ws_q   <= ws_d;
      last_q <= last_d;
      pf_q   <= pf_d;
      seen_q <= seen_d;
      ov_q   <= ov_d;
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_PPR:     ppr_q     <= cfg_data_i[7:0];
          REG_WINDOW:  window_q  <= cfg_data_i;
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // working payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    us_q    <= us_d;
    elap_q  <= elap_d;
    puls_q  <= puls_d;
    den_q   <= den_d;
    res_q   <= res_d;
    orpm_q  <= orpm_d;
    okind_q <= okind_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = orpm_q;
  assign m_axis_tuser  = okind_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the fan tachometer rpm meter: stream driver, answer monitor, predictor
`default_nettype none

module tb_top;
  import ftrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // rpm arithmetic constants, all 32 bit so products wrap as the block does
  localparam logic [31:0] MsPerMinute = 32'd60000;
  localparam logic [31:0] UsPerMinute = 32'd60000000;
  localparam logic [31:0] UsPerMilli  = 32'd1000;
  localparam logic [31:0] WeightOld   = 32'd3;
  localparam logic [31:0] WeightDiv   = 32'd4;

  // idle time after draining, covering the tail of a full query
  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 1000000;
  localparam int RunBeats    = 200;
  localparam int NumPhases   = 6;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } cmd_beat_t;

  typedef struct packed {
    logic [31:0] rpm;
    kind_e       kind;
  } rpm_answer_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;  // [31:0] now_us, [63:32] now_ms
  logic [1:0]        s_axis_tuser  = '0;  // [1:0] cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] rpm
  logic              m_axis_tuser;        // [0] query_kind
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i   = '0;
  logic [DataW-1:0]  cfg_data_i    = '0;

  // beats waiting to be sent, and answers the predictor says must come back
  cmd_beat_t   cmd_beats_q[$];
  rpm_answer_t rpm_expected_q[$];
  cmd_beat_t   cur_beat;

  // mirror of the block's registers and measurement state
  logic [7:0]  cfg_ppr;
  logic [31:0] cfg_window_ms;
  logic [31:0] cfg_timeout_ms;
  logic [31:0] tach_pulses;
  logic [31:0] win_start_ms;
  logic [31:0] last_edge_us;
  logic [31:0] period_us;
  logic        have_edge;

  int idle_pct  = 37;  // chance in a hundred that either side holds off
  int err_count = 0;
  int cycles    = 0;

  fan_tach_rpm_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // advance the meter mirror by one accepted command beat and queue any answer
  task automatic meter_step(input cmd_beat_t b);
    logic [31:0] elapsed, num, den, delta, age, limit, rpm;
    rpm = '0;
    case (b.cmd)
      CMD_EDGE: begin
        tach_pulses = tach_pulses + 32'd1;
        if (have_edge) begin
          delta = b.now_us - last_edge_us;
          // a zero filter value means no period yet, so the next one seeds it
          if (period_us == '0) period_us = delta;
          else period_us = (period_us * WeightOld + delta) / WeightDiv;
        end
        last_edge_us = b.now_us;
        have_edge    = 1'b1;
      end
      CMD_WINDOW: begin
        elapsed = b.now_ms - win_start_ms;
        // an early query answers zero and leaves the window running
        if (elapsed >= cfg_window_ms) begin
          num          = tach_pulses * MsPerMinute;
          den          = elapsed * {24'd0, cfg_ppr};
          tach_pulses  = '0;
          win_start_ms = b.now_ms;
          if (den != '0) rpm = num / den;
        end
        rpm_expected_q.push_back('{rpm: rpm, kind: KIND_WINDOW});
      end
      CMD_INSTANT: begin
        age   = b.now_us - last_edge_us;
        limit = cfg_timeout_ms * UsPerMilli;
        // an age equal to the timeout still counts
        if (have_edge && period_us != '0 && cfg_ppr != '0 && age <= limit) begin
          den = period_us * {24'd0, cfg_ppr};
          if (den != '0) rpm = UsPerMinute / den;
        end
        rpm_expected_q.push_back('{rpm: rpm, kind: KIND_INSTANT});
      end
      default: ;  // unused command is dropped
    endcase
  endtask

  // command driver: holds a beat until taken, then maybe idles
  always @(posedge clk_i) begin
    logic go;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) meter_step(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        go = (cmd_beats_q.size() != 0) && ($urandom_range(99) >= idle_pct);
        if (go) begin
          cur_beat      = cmd_beats_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_beat.now_ms, cur_beat.now_us};
          s_axis_tuser  <= cur_beat.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // answer monitor: random back-pressure, every beat checked against the oldest prediction
  always @(posedge clk_i) begin
    rpm_answer_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rpm_expected_q.size() == 0) begin
          $error("answer beat with none expected: rpm %0d kind %0d", m_axis_tdata, m_axis_tuser);
          err_count++;
        end else begin
          want = rpm_expected_q.pop_front();
          if (m_axis_tdata !== want.rpm) begin
            $error("rpm: expected %0d, got %0d", want.rpm, m_axis_tdata);
            err_count++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("query_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            err_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_beat(input cmd_e cmd, input logic [31:0] us, input logic [31:0] ms);
    cmd_beats_q.push_back('{cmd: cmd, now_us: us, now_ms: ms});
  endtask

  // one register write beat; the mirror follows once the write is taken
  task automatic cfg_write(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PPR:     cfg_ppr        = val[7:0];
      REG_WINDOW:  cfg_window_ms  = val;
      REG_TIMEOUT: cfg_timeout_ms = val;
      default: ;
    endcase
  endtask

  // sender holds off until every beat is out and every answer is back
  task automatic wait_drained();
    while (cmd_beats_q.size() != 0 || s_axis_tvalid || rpm_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // a fan spinning at a drifting period, with queries and some noise mixed in
  task automatic fan_run(input int count);
    int i, r, period, pick;
    logic [31:0] t_us, ms_base, q_us;
    t_us    = $urandom();
    ms_base = $urandom();
    period  = 5000;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        pick = $urandom_range(99);
        if (pick < 10) period = $urandom_range(1, 16);
        else if (pick < 90) period = $urandom_range(300, 30000);
        else period = $urandom_range(100000, 3000000);
      end
      r = $urandom_range(99);
      if (r < 5) begin
        // noise: anything the fields allow
        push_beat(cmd_e'($urandom_range(3)), $urandom(), $urandom());
      end else if (r < 60) begin
        t_us = t_us + period + $urandom_range(0, period / 8);
        // now and then the fan stalls long enough to time out
        if ($urandom_range(99) < 3) t_us = t_us + $urandom_range(0, 2000000);
        push_beat(CMD_EDGE, t_us, ms_base + t_us / 1000);
      end else if (r < 80) begin
        push_beat(CMD_WINDOW, $urandom(), ms_base + t_us / 1000 + $urandom_range(0, 2));
      end else if (r < 99) begin
        q_us = ($urandom_range(3) == 0) ? t_us : t_us + $urandom_range(0, 2 * period);
        push_beat(CMD_INSTANT, q_us, $urandom());
      end else begin
        push_beat(CMD_NONE, t_us, ms_base + t_us / 1000);
      end
    end
  endtask

  initial begin
    int ph;
    cfg_ppr        = 8'd2;
    cfg_window_ms  = 32'd1000;
    cfg_timeout_ms = 32'd500;
    tach_pulses    = '0;
    win_start_ms   = '0;
    last_edge_us   = '0;
    period_us      = '0;
    have_edge      = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at reset settings
    push_beat(CMD_INSTANT, 32'd0, 32'd0);                // no edge yet
    push_beat(CMD_WINDOW, 32'd0, 32'd0);                 // window not elapsed
    push_beat(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused command
    push_beat(CMD_EDGE, 32'd0, 32'd0);                   // edge at time zero
    push_beat(CMD_INSTANT, 32'd10, 32'd0);               // edge but no period
    push_beat(CMD_EDGE, 32'd0, 32'd0);                   // zero period, filter stays empty
    push_beat(CMD_INSTANT, 32'd0, 32'd0);
    push_beat(CMD_EDGE, 32'd20000, 32'd0);               // seeds the filter
    push_beat(CMD_INSTANT, 32'd20000, 32'd0);
    push_beat(CMD_INSTANT, 32'd520000, 32'd0);           // age exactly the timeout
    push_beat(CMD_INSTANT, 32'd520001, 32'd0);           // one past the timeout
    push_beat(CMD_EDGE, 32'd20001, 32'd0);
    push_beat(CMD_EDGE, 32'd20002, 32'd0);
    push_beat(CMD_WINDOW, 32'd0, 32'd999);
    push_beat(CMD_WINDOW, 32'd0, 32'd1000);              // first full window
    push_beat(CMD_WINDOW, 32'd0, 32'd1000);              // just restarted
    push_beat(CMD_EDGE, 32'hFFFF_FFFF, 32'd0);           // huge delta, filter wraps
    push_beat(CMD_EDGE, 32'd5, 32'd0);                   // time wraps
    push_beat(CMD_INSTANT, 32'd10, 32'hFFFF_FFFF);
    push_beat(CMD_WINDOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // huge elapsed, denominator wraps
    push_beat(CMD_WINDOW, 32'd0, 32'h7FFF_FFFF);         // denominator wraps to zero
    wait_drained();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_PPR, 32'd0);
          cfg_write(REG_WINDOW, 32'd0);
          cfg_write(REG_TIMEOUT, 32'd0);
          cfg_write(REG_NONE, $urandom());
        end
        1: begin
          cfg_write(REG_PPR, 32'd255);
          cfg_write(REG_WINDOW, 32'hFFFF_FFFF);
          cfg_write(REG_TIMEOUT, 32'hFFFF_FFFF);
        end
        2: begin
          cfg_write(REG_PPR, 32'd1);
          cfg_write(REG_WINDOW, 32'd20);
          cfg_write(REG_TIMEOUT, 32'd100);
        end
        3: begin
          cfg_write(REG_PPR, $urandom_range(1, 4));
          cfg_write(REG_WINDOW, $urandom_range(0, 200));
          cfg_write(REG_TIMEOUT, $urandom_range(0, 3000));
        end
        4: begin
          cfg_write(REG_PPR, $urandom_range(1, 255));
          cfg_write(REG_WINDOW, $urandom_range(0, 50));
          cfg_write(REG_TIMEOUT, $urandom());
        end
        default: begin
          cfg_write(REG_PPR, $urandom());
          cfg_write(REG_WINDOW, $urandom());
          cfg_write(REG_TIMEOUT, $urandom());
        end
      endcase
      // one phase runs flat out on both sides
      idle_pct = (ph == 2) ? 0 : 37;
      fan_run(RunBeats);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
